FILE: src/agcp_pkg.sv
// Shared constants and types for the ASCII gain command parser.
// Used by the parser top level and its port checker; depends on nothing.
package agcp_pkg;

   localparam int MAX_CHARS_DEFAULT = 16;

   localparam int BYTE_W  = 8;
   localparam int ACC_W   = 63;
   localparam int COUNT_W = 5;

   localparam logic [BYTE_W-1:0] SYM_HASH   = 8'h23;
   localparam logic [BYTE_W-1:0] SYM_P      = 8'h50;
   localparam logic [BYTE_W-1:0] SYM_EQ     = 8'h3D;
   localparam logic [BYTE_W-1:0] SYM_BANG   = 8'h21;
   localparam logic [BYTE_W-1:0] SYM_MINUS  = 8'h2D;
   localparam logic [BYTE_W-1:0] SYM_POINT  = 8'h2E;
   localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'd48;

   typedef enum logic [4:0] {
      PH_WAIT_HASH = 5'b00001,
      PH_WAIT_P    = 5'b00010,
      PH_TAKE_ID   = 5'b00100,
      PH_WAIT_EQ   = 5'b01000,
      PH_TEXT      = 5'b10000
   } phase_type;

endpackage

FILE: src/ascii_gain_command_parser.sv
// Frame parser for '#','P',id,'=',text,'!' commands with on-the-fly decimal conversion.
// Depends on agcp_pkg for symbols, widths and the phase type.
//
// The result of a frame is registered: it appears on rsp_* in the cycle after its '!' item is accepted.
// Throughput: one byte item per cycle; input stalls only while a finished result waits
// under rsp_stall. The text update (accumulator times ten plus digit) completes in the
// cycle the byte is accepted.
// Reset (synchronous, active high): phase returns to waiting for '#', id and text state
// clear, and the result register empties.
module ascii_gain_command_parser
   import agcp_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // byte input channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [BYTE_W-1:0]        req_rx_byte,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [BYTE_W-1:0]        rsp_target_id,
   output logic signed [ACC_W-1:0]  rsp_mantissa,
   output logic [COUNT_W-1:0]       rsp_frac_digits,
   output logic [COUNT_W-1:0]       rsp_text_length,
   output logic                     rsp_overflow
);

   // Parse state
   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   held_id_ff, held_id_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                after_point_ff, after_point_in;
   logic [COUNT_W-1:0]  frac_count_ff, frac_count_in;
   logic                negative_ff, negative_in;
   logic [COUNT_W-1:0]  char_count_ff, char_count_in;
   logic                dropped_ff, dropped_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_id_ff;
   logic [ACC_W-1:0]    rsp_mant_ff;
   logic [COUNT_W-1:0]  rsp_frac_ff;
   logic [COUNT_W-1:0]  rsp_len_ff;
   logic                rsp_ovf_ff;

   logic                accept;
   logic                emit;
   logic [ACC_W-1:0]    digit;
   logic [ACC_W-1:0]    acc_times_ten;
   logic [ACC_W-1:0]    mant_out;

   // Hold the input only while a finished result waits and is stalled.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Digit value is byte minus 48, wrapping for bytes below '0'.
   assign digit         = ACC_W'(req_rx_byte) - ACC_W'(DIGIT_BASE);
   assign acc_times_ten = (acc_ff << 3) + (acc_ff << 1);
   assign mant_out      = negative_ff ? (ACC_W'(0) - acc_ff) : acc_ff;

   always_comb begin
      phase_in       = phase_ff;
      held_id_in     = held_id_ff;
      acc_in         = acc_ff;
      after_point_in = after_point_ff;
      frac_count_in  = frac_count_ff;
      negative_in    = negative_ff;
      char_count_in  = char_count_ff;
      dropped_in     = dropped_ff;
      emit           = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_WAIT_P: begin
               if (req_rx_byte == SYM_P) phase_in = PH_TAKE_ID;
            end
            PH_TAKE_ID: begin
               // any byte is taken; the id is that byte minus '0'
               held_id_in = req_rx_byte - DIGIT_BASE;
               phase_in   = PH_WAIT_EQ;
            end
            PH_WAIT_EQ: begin
               if (req_rx_byte == SYM_EQ) begin
                  acc_in         = '0;
                  after_point_in = 1'b0;
                  frac_count_in  = '0;
                  negative_in    = 1'b0;
                  char_count_in  = '0;
                  dropped_in     = 1'b0;
                  phase_in       = PH_TEXT;
               end
            end
            PH_TEXT: begin
               if (req_rx_byte == SYM_BANG) begin
                  // close the frame: emit and clear text state
                  emit           = 1'b1;
                  acc_in         = '0;
                  after_point_in = 1'b0;
                  frac_count_in  = '0;
                  negative_in    = 1'b0;
                  char_count_in  = '0;
                  dropped_in     = 1'b0;
                  phase_in       = PH_WAIT_HASH;
               end else if (char_count_ff >= COUNT_W'(MAX_CHARS)) begin
                  // drop characters past the limit, minus and point included
                  dropped_in = 1'b1;
               end else begin
                  char_count_in = char_count_ff + COUNT_W'(1);
                  if (req_rx_byte == SYM_MINUS) begin
                     negative_in = 1'b1;
                  end else if (!after_point_ff && req_rx_byte == SYM_POINT) begin
                     after_point_in = 1'b1;
                  end else begin
                     acc_in = acc_times_ten + digit;
                     if (after_point_ff) frac_count_in = frac_count_ff + COUNT_W'(1);
                  end
               end
            end
            default: begin
               // waiting for '#'; unused phase codes land here too
               phase_in = (req_rx_byte == SYM_HASH) ? PH_WAIT_P : PH_WAIT_HASH;
            end
         endcase
      end
   end

   // Keep a result until taken; a new one may load in the cycle the old one leaves.
   assign rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT_HASH;
         held_id_ff     <= '0;
         acc_ff         <= '0;
         after_point_ff <= 1'b0;
         frac_count_ff  <= '0;
         negative_ff    <= 1'b0;
         char_count_ff  <= '0;
         dropped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         held_id_ff     <= held_id_in;
         acc_ff         <= acc_in;
         after_point_ff <= after_point_in;
         frac_count_ff  <= frac_count_in;
         negative_ff    <= negative_in;
         char_count_ff  <= char_count_in;
         dropped_ff     <= dropped_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload: load on emit only, no reset needed.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_id_ff   <= held_id_ff;
         rsp_mant_ff <= mant_out;
         rsp_frac_ff <= frac_count_ff;
         rsp_len_ff  <= char_count_ff;
         rsp_ovf_ff  <= dropped_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target_id   = rsp_id_ff;
   assign rsp_mantissa    = $signed(rsp_mant_ff);
   assign rsp_frac_digits = rsp_frac_ff;
   assign rsp_text_length = rsp_len_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

FILE: src/agcp_checker.sv
// Port-level checker for the ASCII gain command parser, bound to the top level.
// Depends on agcp_pkg for symbols and widths.
module agcp_assertions
   import agcp_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [BYTE_W-1:0]        req_rx_byte,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [BYTE_W-1:0]        rsp_target_id,
   input logic signed [ACC_W-1:0]  rsp_mantissa,
   input logic [COUNT_W-1:0]       rsp_frac_digits,
   input logic [COUNT_W-1:0]       rsp_text_length,
   input logic                     rsp_overflow
);

   // A new result only follows an accepted '!'.
   a_result_from_bang: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_rx_byte == SYM_BANG))
      else $error("result appeared without an accepted closing byte");

   // Input is held back only by a stalled pending result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a pending stalled result");

   // A stalled result stays put.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_mantissa)
         && $stable(rsp_target_id) && $stable(rsp_text_length)))
      else $error("stalled result changed");

   // Counts stay consistent: the point itself is a counted character, and
   // dropping only happens once the limit is reached.
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_frac_digits == '0 || rsp_frac_digits < rsp_text_length)
         && rsp_text_length <= COUNT_W'(MAX_CHARS)
         && (!rsp_overflow || rsp_text_length == COUNT_W'(MAX_CHARS))))
      else $error("inconsistent character counts in result");

endmodule

bind ascii_gain_command_parser agcp_assertions #(.MAX_CHARS(MAX_CHARS)) u_agcp_assertions (.*);
